### hdl/ufd_pkg.sv
// ufd_pkg: shared types and constants of the UTF-8 stream decoder.
// Holds the result entry and result bundle types used by the decoder,
// the output serializer and the top level. No dependencies.
package ufd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned MaxRes = 4;
  localparam int unsigned CntW   = 3;   // holds 0..MaxRes
  localparam int unsigned IdxW   = 2;   // indexes 0..MaxRes-1
  localparam int unsigned OutDataW = 24;

  localparam logic KindCodePoint = 1'b0;
  localparam logic KindError     = 1'b1;

  typedef struct packed {
    logic           kind;
    logic [CpW-1:0] code_point;
    logic           text_valid;
  } res_t;

  typedef struct packed {
    logic [CntW-1:0]    count;
    res_t [MaxRes-1:0]  ent;
  } bundle_t;

endpackage

### hdl/utf8_stream_decoder.sv
// utf8_stream_decoder: top level of the strict UTF-8 stream decoder.
// Depends on ufd_pkg, ufd_decode and ufd_out_queue.
//
// One byte per input request, with in_tlast marking the last byte of a text.
// Each byte is decoded in one pass of logic into a bundle of zero to four
// results, held in a result register and handed out one per cycle while
// out_tready is high. A new byte is taken while the previous bundle's last
// result is being taken, so plain text runs at one byte per cycle with
// out_tready high; new bytes wait until the output port drains the bundle.
// Lead bytes without end of text give no result. Overlong forms, surrogates,
// values above 0x10FFFF and bad lead bytes give one error result per byte
// involved; a byte that breaks an open sequence is decoded afresh. The
// text_valid bit is sticky within a text and clears after in_tlast.
module utf8_stream_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ufd_pkg::ByteW-1:0]         in_tdata,  // [7:0] data_byte
  input  logic                              in_tlast,  // end_of_text
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ufd_pkg::OutDataW-1:0]      out_tdata, // [20:0] code_point, [21] text_valid
  output logic                              out_tuser, // kind: 0 code point, 1 error
  output logic                              out_tlast  // last_of_run
);

  logic              take;
  logic              free;
  ufd_pkg::bundle_t  bundle;
  ufd_pkg::res_t     res;

  // Advance the decoder only on an accepted request.
  assign take      = in_tvalid && free;
  assign in_tready = free;

  ufd_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .data_byte   (in_tdata),
    .end_of_text (in_tlast),
    .bundle      (bundle)
  );

  ufd_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .bundle    (bundle),
    .free      (free),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res),
    .res_last  (out_tlast)
  );

  // Pack the result fields; pad bits stay zero.
  assign out_tdata = {2'b00, res.text_valid, res.code_point};
  assign out_tuser = res.kind;

endmodule

### hdl/ufd_decode.sv
// ufd_decode: per-byte UTF-8 decode step and the sequence state registers.
// Builds the bundle of up to four results caused by one request.
// Depends on ufd_pkg.
module ufd_decode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic [ufd_pkg::ByteW-1:0]   data_byte,
  input  logic                        end_of_text,
  output ufd_pkg::bundle_t            bundle
);

  localparam logic [ufd_pkg::CpW-1:0] Min2      = 21'h000080;
  localparam logic [ufd_pkg::CpW-1:0] Min3      = 21'h000800;
  localparam logic [ufd_pkg::CpW-1:0] SurLo     = 21'h00D800;
  localparam logic [ufd_pkg::CpW-1:0] SurHi     = 21'h00DFFF;
  localparam logic [ufd_pkg::CpW-1:0] Min4      = 21'h010000;
  localparam logic [ufd_pkg::CpW-1:0] MaxCp     = 21'h10FFFF;

  logic [ufd_pkg::CpW-1:0] acc_r, acc_nxt;
  logic [1:0]              held_r, held_nxt;
  logic [2:0]              len_r, len_nxt;
  logic                    err_r, err_nxt;

  logic                    cont;
  logic                    fresh;
  logic                    value_ok;
  logic [ufd_pkg::CpW-1:0] acc_ext;
  logic [2:0]              now;
  logic [2:0]              pre_cnt;
  logic                    main_v;
  logic                    main_err;
  logic [ufd_pkg::CpW-1:0] main_cp;
  logic [1:0]              flush_cnt;
  logic [2:0]              n;
  logic                    run_err;
  logic                    is_main;
  logic                    ent_err;

  // Sequence decode: held bytes first, then the byte afresh, then end flush.
  always_comb begin
    cont     = (data_byte[7:6] == 2'b10);
    acc_ext  = {acc_r[14:0], data_byte[5:0]};
    now      = {1'b0, held_r} + 3'd1;
    acc_nxt  = acc_r;
    held_nxt = held_r;
    len_nxt  = len_r;
    pre_cnt  = 3'd0;
    main_v   = 1'b0;
    main_err = 1'b0;
    main_cp  = '0;
    fresh    = 1'b1;

    unique case (len_r)
      3'd2:    value_ok = (acc_ext >= Min2);
      3'd3:    value_ok = (acc_ext >= Min3) && !((acc_ext >= SurLo) && (acc_ext <= SurHi));
      3'd4:    value_ok = (acc_ext >= Min4) && (acc_ext <= MaxCp);
      default: value_ok = 1'b0;
    endcase

    if (held_r != 2'd0) begin
      if (cont) begin
        fresh = 1'b0;
        if (now >= len_r) begin
          if (value_ok) begin
            main_v  = 1'b1;
            main_cp = acc_ext;
          end else begin
            pre_cnt = now;
          end
          acc_nxt  = '0;
          held_nxt = 2'd0;
          len_nxt  = 3'd0;
        end else begin
          acc_nxt  = acc_ext;
          held_nxt = now[1:0];
        end
      end else begin
        pre_cnt  = {1'b0, held_r};
        acc_nxt  = '0;
        held_nxt = 2'd0;
        len_nxt  = 3'd0;
      end
    end

    if (fresh) begin
      if (!data_byte[7]) begin
        main_v  = 1'b1;
        main_cp = {13'd0, data_byte};
      end else if (data_byte[7:5] == 3'b110) begin
        acc_nxt  = {16'd0, data_byte[4:0]};
        len_nxt  = 3'd2;
        held_nxt = 2'd1;
      end else if (data_byte[7:4] == 4'b1110) begin
        acc_nxt  = {17'd0, data_byte[3:0]};
        len_nxt  = 3'd3;
        held_nxt = 2'd1;
      end else if (data_byte[7:3] == 5'b11110) begin
        acc_nxt  = {18'd0, data_byte[2:0]};
        len_nxt  = 3'd4;
        held_nxt = 2'd1;
      end else begin
        main_v   = 1'b1;
        main_err = 1'b1;
      end
    end

    flush_cnt = 2'd0;
    if (end_of_text) begin
      flush_cnt = held_nxt;
      acc_nxt   = '0;
      held_nxt  = 2'd0;
      len_nxt   = 3'd0;
    end
  end

  // Lay out the results: held errors, the main result, then flushed errors.
  always_comb begin
    n       = pre_cnt + {2'd0, main_v} + {1'b0, flush_cnt};
    run_err = 1'b0;
    is_main = 1'b0;
    ent_err = 1'b0;
    bundle.count = n;
    for (int i = 0; i < ufd_pkg::MaxRes; i++) begin
      is_main = main_v && (3'(i) == pre_cnt);
      ent_err = !(is_main && !main_err);
      run_err = run_err | (ent_err && (3'(i) < n));
      bundle.ent[i].kind       = ent_err ? ufd_pkg::KindError : ufd_pkg::KindCodePoint;
      bundle.ent[i].code_point = ent_err ? '0 : main_cp;
      bundle.ent[i].text_valid = !(err_r | run_err);
    end
    err_nxt = end_of_text ? 1'b0 : (err_r | run_err);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      held_r <= 2'd0;
      len_r  <= 3'd0;
      err_r  <= 1'b0;
    end else if (take) begin
      acc_r  <= acc_nxt;
      held_r <= held_nxt;
      len_r  <= len_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

### hdl/ufd_out_queue.sv
// ufd_out_queue: result register for one bundle; its entries go out one per
// cycle while res_ready is high, the final one marked. Depends on ufd_pkg.
module ufd_out_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  ufd_pkg::bundle_t      bundle,
  output logic                  free,
  output logic                  res_valid,
  input  logic                  res_ready,
  output ufd_pkg::res_t         res,
  output logic                  res_last
);

  ufd_pkg::bundle_t                 bnd_r;
  logic [ufd_pkg::IdxW-1:0]         idx_r;
  logic                             vld_r;
  logic                             done;

  assign res_valid = vld_r;
  assign res       = bnd_r.ent[idx_r];
  assign res_last  = (({1'b0, idx_r} + 3'd1) == bnd_r.count);
  assign done      = vld_r && res_ready && res_last;
  assign free      = !vld_r || done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (load && (bundle.count != '0)) begin
      vld_r <= 1'b1;
      idx_r <= '0;
    end else if (done) begin
      vld_r <= 1'b0;
    end else if (vld_r && res_ready) begin
      idx_r <= idx_r + ufd_pkg::IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bnd_r <= bundle;
    end
  end

endmodule

### test/tb_utf8_stream_decoder.sv
// tb_utf8_stream_decoder: self-checking testbench of the strict UTF-8 stream decoder.
// Sends a directed byte table, then random streams; checks each result against its
// typed row or an in-bench decoder model. Depends on ufd_pkg and utf8_stream_decoder.
module tb_utf8_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ByteW    = ufd_pkg::ByteW;
  localparam int unsigned CpW      = ufd_pkg::CpW;
  localparam int unsigned OutDataW = ufd_pkg::OutDataW;
  localparam logic KindCodePoint   = ufd_pkg::KindCodePoint;
  localparam logic KindError       = ufd_pkg::KindError;

  localparam int unsigned StallLimit = 200;  // cycles without any accepted request
  localparam int unsigned ReportMax  = 10;

  // Lower bounds of each encoded length and the forbidden ranges.
  localparam logic [CpW-1:0] MinTwoByte   = 21'h80;
  localparam logic [CpW-1:0] MinThreeByte = 21'h800;
  localparam logic [CpW-1:0] MinFourByte  = 21'h10000;
  localparam logic [CpW-1:0] SurrLow      = 21'hD800;
  localparam logic [CpW-1:0] SurrHigh     = 21'hDFFF;
  localparam logic [CpW-1:0] MaxScalar    = 21'h10FFFF;

  // One decoded result as it leaves the block.
  typedef struct packed {
    logic           kind;
    logic [CpW-1:0] cp;
    logic           tv;
    logic           last;
  } dec_res_t;

  // One row of the directed table; the result fields count only when typed is set.
  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             eot;
    logic             typed;
    logic             kind;
    logic [CpW-1:0]   cp;
    logic             tv;
  } dir_row_t;

  localparam int unsigned NumRows = 26;
  localparam dir_row_t DirRows [NumRows] = '{
    // lowest and highest ASCII right after reset
    '{8'h00, 1'b0, 1'b1, KindCodePoint, 21'h00, 1'b1},
    '{8'h7F, 1'b0, 1'b1, KindCodePoint, 21'h7F, 1'b1},
    // stray continuation byte, then a bad lead that also ends the text
    '{8'h80, 1'b0, 1'b1, KindError,     21'h00, 1'b0},
    '{8'hFF, 1'b1, 1'b1, KindError,     21'h00, 1'b0},
    // sticky flag is clear again in the new text
    '{8'h41, 1'b0, 1'b1, KindCodePoint, 21'h41, 1'b1},
    // smallest two-byte value
    '{8'hC2, 1'b0, 1'b0, KindCodePoint, 21'h00, 1'b0},
    '{8'h80, 1'b0, 1'b0, KindCodePoint, 21'h00, 1'b0},
    // largest scalar value
    '{8'hF4, 1'b0, 1'b0, KindCodePoint, 21'h00, 1'b0},
    '{8'h8F, 1'b0, 1'b0, KindCodePoint, 21'h00, 1'b0},
    '{8'hBF, 1'b0, 1'b0, KindCodePoint, 21'h00, 1'b0},
    '{8'hBF, 1'b0, 1'b0, KindCodePoint, 21'h00, 1'b0},
    // overlong two-byte form from a C0 lead
    '{8'hC0, 1'b0, 1'b0, KindCodePoint, 21'h00, 1'b0},
    '{8'h80, 1'b0, 1'b0, KindCodePoint, 21'h00, 1'b0},
    // surrogate
    '{8'hED, 1'b0, 1'b0, KindCodePoint, 21'h00, 1'b0},
    '{8'hA0, 1'b0, 1'b0, KindCodePoint, 21'h00, 1'b0},
    '{8'h80, 1'b0, 1'b0, KindCodePoint, 21'h00, 1'b0},
    // F5 lead: too big, four errors on the closing byte, which also ends the text
    '{8'hF5, 1'b0, 1'b0, KindCodePoint, 21'h00, 1'b0},
    '{8'h80, 1'b0, 1'b0, KindCodePoint, 21'h00, 1'b0},
    '{8'h80, 1'b0, 1'b0, KindCodePoint, 21'h00, 1'b0},
    '{8'h80, 1'b1, 1'b0, KindCodePoint, 21'h00, 1'b0},
    // open sequence broken by ASCII, which is then decoded afresh
    '{8'hE0, 1'b0, 1'b0, KindCodePoint, 21'h00, 1'b0},
    '{8'hA0, 1'b0, 1'b0, KindCodePoint, 21'h00, 1'b0},
    '{8'h41, 1'b0, 1'b0, KindCodePoint, 21'h00, 1'b0},
    // end of text with two bytes held flushes them
    '{8'hE1, 1'b0, 1'b0, KindCodePoint, 21'h00, 1'b0},
    '{8'h80, 1'b1, 1'b0, KindCodePoint, 21'h00, 1'b0},
    // lead byte that is itself the end of text
    '{8'hF0, 1'b1, 1'b0, KindCodePoint, 21'h00, 1'b0}
  };

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [ByteW-1:0]    in_tdata   = '0;
  logic                in_tlast   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;
  logic                out_tlast;

  // Row info that travels with the byte on the input request.
  logic                cur_typed     = 1'b0;
  dec_res_t            cur_typed_res = '0;

  // Decoder model state.
  logic [CpW-1:0]      acc_bits = '0;
  logic [1:0]          held     = '0;
  logic [2:0]          seq_len  = '0;
  logic                err_seen = 1'b0;

  dec_res_t            byte_results [$];   // results of the byte just decoded
  dec_res_t            pending_chars [$];  // results still owed by the block

  bit                  gaps_on    = 1'b1;
  bit                  in_fire_q  = 1'b0;
  bit                  out_fire_q = 1'b0;
  int unsigned         mismatches     = 0;
  int unsigned         bytes_sent     = 0;
  int unsigned         results_seen   = 0;
  int unsigned         errors_seen    = 0;

  utf8_stream_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin : clock_gen
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  // Append one result; an error sets the sticky flag before text_valid is taken.
  task automatic push_result(input logic is_err, input logic [CpW-1:0] cp);
    dec_res_t r;
    if (is_err) err_seen = 1'b1;
    r.kind = is_err ? KindError : KindCodePoint;
    r.cp   = is_err ? '0 : cp;
    r.tv   = !err_seen;
    r.last = 1'b0;
    byte_results.push_back(r);
  endtask

  task automatic clear_seq();
    acc_bits = '0;
    held     = '0;
    seq_len  = '0;
  endtask

  // Decode one byte into byte_results and advance the model state.
  task automatic decode_byte(input logic [ByteW-1:0] b, input logic eot);
    logic [CpW-1:0] acc;
    int unsigned    now;
    bit             taken;
    bit             ok;
    taken = 1'b0;
    byte_results = {};
    if (held != 0) begin
      if (b[7:6] == 2'b10) begin
        acc   = {acc_bits[CpW-7:0], b[5:0]};
        now   = held + 1;
        taken = 1'b1;
        if (now >= seq_len) begin
          // complete sequence: reject overlong, surrogate and out-of-range values
          case (seq_len)
            3'd2:    ok = acc >= MinTwoByte;
            3'd3:    ok = acc >= MinThreeByte && !(acc >= SurrLow && acc <= SurrHigh);
            default: ok = acc >= MinFourByte && acc <= MaxScalar;
          endcase
          if (ok) push_result(1'b0, acc);
          else repeat (now) push_result(1'b1, '0);
          clear_seq();
        end else begin
          acc_bits = acc;
          held     = now[1:0];
        end
      end else begin
        // broken sequence: drop every held byte as an error, then decode b afresh
        repeat (held) push_result(1'b1, '0);
        clear_seq();
      end
    end
    if (!taken) begin
      if (!b[7]) begin
        push_result(1'b0, {{(CpW-ByteW){1'b0}}, b});
      end else if (b[7:5] == 3'b110) begin
        acc_bits = {16'b0, b[4:0]};
        seq_len  = 3'd2;
        held     = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        acc_bits = {17'b0, b[3:0]};
        seq_len  = 3'd3;
        held     = 2'd1;
      end else if (b[7:3] == 5'b11110) begin
        acc_bits = {18'b0, b[2:0]};
        seq_len  = 3'd4;
        held     = 2'd1;
      end else begin
        push_result(1'b1, '0);
      end
    end
    if (eot) begin
      // flush whatever is still held at end of text
      repeat (held) push_result(1'b1, '0);
      clear_seq();
    end
    if (byte_results.size() > 0) byte_results[byte_results.size()-1].last = 1'b1;
    if (eot) err_seen = 1'b0;
  endtask

  // Pack a value into 1..4 bytes of UTF-8 shape, first byte in the low bits. No
  // range check, so overlong and oversized forms come out as well.
  function automatic logic [31:0] utf8_bytes(input logic [CpW-1:0] cp, input int unsigned len);
    case (len)
      1:       return {24'b0, 1'b0, cp[6:0]};
      2:       return {16'b0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
      3:       return {8'b0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      default: return {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    dec_res_t got;
    dec_res_t want;
    in_fire_q  = rst_n && in_tvalid && in_tready;
    out_fire_q = rst_n && out_tvalid && out_tready;

    // Check the result first: it can never belong to a byte taken at this same edge.
    if (out_fire_q) begin
      got.kind = out_tuser;
      got.cp   = out_tdata[CpW-1:0];
      got.tv   = out_tdata[CpW];
      got.last = out_tlast;
      results_seen++;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("[%0t] result with nothing owed: kind=%0b cp=%06h tv=%0b last=%0b",
                   $realtime, got.kind, got.cp, got.tv, got.last);
      end else begin
        want = pending_chars.pop_front();
        if (want.kind == KindError) errors_seen++;
        if (got !== want || out_tdata[OutDataW-1:CpW+1] !== '0) begin
          mismatches++;
          if (mismatches <= ReportMax) begin
            $display("[%0t] result mismatch: want kind=%0b cp=%06h tv=%0b last=%0b",
                     $realtime, want.kind, want.cp, want.tv, want.last);
            $display("[%0t]                   got kind=%0b cp=%06h tv=%0b last=%0b pad=%0h",
                     $realtime, got.kind, got.cp, got.tv, got.last,
                     out_tdata[OutDataW-1:CpW+1]);
          end
        end
      end
    end

    // Decode the accepted byte; typed table rows supply their own result.
    if (in_fire_q) begin
      bytes_sent++;
      decode_byte(in_tdata, in_tlast);
      if (cur_typed) pending_chars.push_back(cur_typed_res);
      else foreach (byte_results[i]) pending_chars.push_back(byte_results[i]);
    end
  end

  // Watchdog: end the run when no request moves for too long.
  initial begin : watchdog
    int unsigned idle_run;
    idle_run = 0;
    while (idle_run < StallLimit) begin
      @(negedge clk);
      if (!rst_n || in_fire_q || out_fire_q) idle_run = 0;
      else idle_run++;
    end
    $display("[%0t] no request accepted for %0d cycles", $realtime, StallLimit);
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: hold off out_tready in random bursts while gaps are enabled
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!gaps_on)
        stall_left = 0;
      else if (stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 13);
      if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one byte at the falling edge, maybe after an idle burst, and hold it
  // until the request is taken. Leaves in_tvalid high on return.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic eot,
                           input logic typed, input dec_res_t typed_res);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid     <= 1'b1;
    in_tdata      <= b;
    in_tlast      <= eot;
    cur_typed     <= typed;
    cur_typed_res <= typed_res;
    do @(negedge clk); while (!in_fire_q);
  endtask

  // Send about target bytes: mostly well-formed characters with random values,
  // the rest overlong or oversized forms, surrogates, cut-off sequences and noise.
  task automatic send_random(input int unsigned target);
    int unsigned    sent;
    int unsigned    pick;
    int unsigned    len;
    int unsigned    keep;
    logic [CpW-1:0] cp;
    logic [31:0]    seq;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = $urandom_range(1, 4);
        case (len)
          1:       cp = CpW'($urandom_range(0, 'h7F));
          2:       cp = CpW'($urandom_range('h80, 'h7FF));
          3:       cp = CpW'($urandom_range('h800, 'hFFFF));
          default: cp = CpW'($urandom_range('h10000, 'h10FFFF));
        endcase
        seq  = utf8_bytes(cp, len);
        keep = len;
      end else if (pick < 80) begin
        // overlong form, or a four-byte value above the last scalar
        len = $urandom_range(2, 4);
        case (len)
          2:       cp = CpW'($urandom_range(0, 'h7F));
          3:       cp = CpW'($urandom_range(0, 'h7FF));
          default: cp = CpW'($urandom_range(0, 1) ? $urandom_range(0, 'hFFFF)
                                                  : $urandom_range('h110000, 'h1FFFFF));
        endcase
        seq  = utf8_bytes(cp, len);
        keep = len;
      end else if (pick < 85) begin
        cp   = CpW'($urandom_range(SurrLow, SurrHigh));
        seq  = utf8_bytes(cp, 3);
        keep = 3;
      end else if (pick < 93) begin
        // cut the sequence short so that the next byte breaks it
        len  = $urandom_range(2, 4);
        cp   = CpW'($urandom);
        seq  = utf8_bytes(cp, len);
        keep = $urandom_range(1, len - 1);
      end else begin
        seq  = $urandom_range(0, 255);
        keep = 1;
      end
      for (int unsigned i = 0; i < keep; i++) begin
        send_byte(seq[8*i +: 8],
                  (i == keep - 1) ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 39) == 0),
                  1'b0, '0);
        sent++;
      end
    end
  endtask

  // Wait at the falling edge until every owed result has been taken.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    dec_res_t row_res;

    // Hold reset, then release it at a falling edge.
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table.
    foreach (DirRows[k]) begin
      row_res.kind = DirRows[k].kind;
      row_res.cp   = DirRows[k].cp;
      row_res.tv   = DirRows[k].tv;
      row_res.last = 1'b1;
      send_byte(DirRows[k].b, DirRows[k].eot, DirRows[k].typed, row_res);
    end

    // Random streams with idle bursts on both sides.
    send_random(60);

    // Pause the sender until the block has handed out everything owed.
    drain();
    send_random(50);

    // Final stretch at full rate, no idling on either side.
    gaps_on = 1'b0;
    send_random(44);

    drain();
    repeat (16) @(negedge clk);

    $display("covered %0d input bytes: %0d results checked, %0d of them byte errors",
             bytes_sent, results_seen, errors_seen);
    $display("forms: 1..4 byte characters, overlong, surrogate, too big, cut-off and noise");
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, pending_chars.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### utf8_stream_decoder.f
hdl/ufd_pkg.sv
hdl/ufd_decode.sv
hdl/ufd_out_queue.sv
hdl/utf8_stream_decoder.sv
test/tb_utf8_stream_decoder.sv
